// File: rtl/palette_fade_engine_top_assert.svh
// Assertion macros used by the palette fade engine controller (pfe_ctrl).
`ifndef PALETTE_FADE_ENGINE_TOP_ASSERT_SVH
`define PALETTE_FADE_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PFE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("palette fade engine: assertion failed");
// Next-cycle implication.
`define PFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("palette fade engine: assertion failed");
`else
`define PFE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PFE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/pfe_pkg.sv
package pfe_pkg;

  // Fixed port field widths
  localparam int ACT_BITS   = 3;
  localparam int IDX_BITS   = 8;
  localparam int OUT_BITS   = 6;
  localparam int COUNT_BITS = 10;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_WR_TARGET  = 3'd0,
    ACT_WR_CURRENT = 3'd1,
    ACT_FILL       = 3'd2,
    ACT_STEP       = 3'd3,
    ACT_READ       = 3'd4
  } action_t;

  // Palette memory strobes from the controller
  typedef struct packed {
    logic rd_en;
    logic cur_we;
    logic tgt_we;
  } mem_ctl_t;

  // One result item, red in the lowest bits
  typedef struct packed {
    logic                  finished;
    logic [COUNT_BITS-1:0] matched_count;
    logic [OUT_BITS-1:0]   blue;
    logic [OUT_BITS-1:0]   green;
    logic [OUT_BITS-1:0]   red;
  } result_t;

endpackage

// File: rtl/pfe_palette_mem.sv
module pfe_palette_mem
  import pfe_pkg::*;
#(
  parameter int ENTRIES      = 256,
  parameter int CHANNEL_BITS = 6,
  localparam int AW = $clog2(ENTRIES),
  localparam int DW = 3 * CHANNEL_BITS
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] cur_rdata,
  output logic [DW-1:0] tgt_rdata
);

  logic [DW-1:0] cur_mem [ENTRIES];
  logic [DW-1:0] tgt_mem [ENTRIES];

  // Current palette: one write port, registered read
  always_ff @(posedge clk) begin
    if (ctl.cur_we) begin
      cur_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      cur_rdata <= cur_mem[rd_addr];
    end
  end

  // Target palette: same address buses
  always_ff @(posedge clk) begin
    if (ctl.tgt_we) begin
      tgt_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      tgt_rdata <= tgt_mem[rd_addr];
    end
  end

endmodule

// File: rtl/pfe_fade_alu.sv
module pfe_fade_alu
  import pfe_pkg::*;
#(
  parameter int CHANNEL_BITS = 6,
  localparam int DW = 3 * CHANNEL_BITS
) (
  input  logic          to_black,
  input  logic [DW-1:0] cur,
  input  logic [DW-1:0] tgt,
  output logic [DW-1:0] nxt,
  output logic [1:0]    match_cnt
);

  logic [2:0] hit;

  // Move each channel one unit toward its goal
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [CHANNEL_BITS-1:0] cur_ch;
    logic [CHANNEL_BITS-1:0] goal;
    logic [CHANNEL_BITS-1:0] nxt_ch;

    assign cur_ch = cur[c*CHANNEL_BITS +: CHANNEL_BITS];
    assign goal   = to_black ? '0 : tgt[c*CHANNEL_BITS +: CHANNEL_BITS];
    assign nxt_ch = (cur_ch < goal) ? cur_ch + CHANNEL_BITS'(1) :
                    (cur_ch > goal) ? cur_ch - CHANNEL_BITS'(1) : cur_ch;
    assign nxt[c*CHANNEL_BITS +: CHANNEL_BITS] = nxt_ch;
    assign hit[c] = (nxt_ch == goal);
  end

  assign match_cnt = 2'(hit[0]) + 2'(hit[1]) + 2'(hit[2]);

endmodule

// File: rtl/pfe_ctrl.sv
`include "palette_fade_engine_top_assert.svh"

module pfe_ctrl
  import pfe_pkg::*;
#(
  parameter int ENTRIES      = 256,
  parameter int CHANNEL_BITS = 6,
  localparam int AW = $clog2(ENTRIES),
  localparam int DW = 3 * CHANNEL_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fade_to_black,
  // item in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACT_BITS-1:0] in_action,
  input  logic [IDX_BITS-1:0] in_index,
  input  logic [OUT_BITS-1:0] in_red,
  input  logic [OUT_BITS-1:0] in_green,
  input  logic [OUT_BITS-1:0] in_blue,
  // palette memories
  output mem_ctl_t            ctl,
  output logic [AW-1:0]       rd_addr,
  output logic [AW-1:0]       wr_addr,
  output logic [DW-1:0]       wr_data,
  input  logic [DW-1:0]       cur_rdata,
  input  logic [DW-1:0]       tgt_rdata,
  // result out
  output logic                res_valid,
  input  logic                res_take,
  output result_t             res
);

  localparam int ACC_W = $clog2(3 * ENTRIES + 1);
  localparam int MW    = (ACC_W > COUNT_BITS) ? ACC_W : COUNT_BITS;
  localparam logic [AW-1:0]    LAST     = AW'(ENTRIES - 1);
  localparam logic [ACC_W-1:0] ALL_HIT  = ACC_W'(3 * ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FILL,
    S_STEP,
    S_REPLY
  } state_t;

  state_t           state;
  logic [AW-1:0]    cnt;
  logic             sweep;
  logic             pend;
  logic [AW-1:0]    pend_addr;
  logic [DW-1:0]    fill_rgb;
  logic [ACC_W-1:0] acc;

  logic             accept;
  logic [AW-1:0]    idx_mod;
  logic [DW-1:0]    in_rgb;
  logic [DW-1:0]    alu_nxt;
  logic [1:0]       alu_match;
  logic [ACC_W-1:0] acc_total;
  logic [COUNT_BITS-1:0] count_sat;
  logic [AW-1:0]    idx_tbl [2**IDX_BITS];

  // Entry index wraps modulo ENTRIES: constant lookup
  for (genvar i = 0; i < 2**IDX_BITS; i++) begin : g_idx
    assign idx_tbl[i] = AW'(i % ENTRIES);
  end
  assign idx_mod = idx_tbl[in_index];

  // Input channels resized to the stored width
  assign in_rgb = {CHANNEL_BITS'(in_blue), CHANNEL_BITS'(in_green), CHANNEL_BITS'(in_red)};

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_REPLY);

  pfe_fade_alu #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_alu (
    .to_black (fade_to_black),
    .cur      (cur_rdata),
    .tgt      (tgt_rdata),
    .nxt      (alu_nxt),
    .match_cnt(alu_match)
  );

  // Match count including the entry being written back
  assign acc_total = acc + ACC_W'(alu_match);
  assign count_sat = (MW'(acc_total) > MW'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(acc_total);

  // Memory strobes and address muxing
  always_comb begin
    ctl     = '0;
    rd_addr = cnt;
    wr_addr = pend_addr;
    wr_data = alu_nxt;
    unique case (state)
      S_IDLE: begin
        rd_addr = idx_mod;
        wr_addr = idx_mod;
        wr_data = in_rgb;
        if (accept) begin
          unique case (in_action)
            ACT_WR_TARGET:  ctl.tgt_we = 1'b1;
            ACT_WR_CURRENT: ctl.cur_we = 1'b1;
            ACT_READ:       ctl.rd_en  = 1'b1;
            default: ;
          endcase
        end
      end
      S_FILL: begin
        wr_addr    = cnt;
        wr_data    = fill_rgb;
        ctl.cur_we = 1'b1;
      end
      // read entry cnt while entry cnt-1 is written back
      S_STEP: begin
        ctl.rd_en  = sweep;
        ctl.cur_we = pend;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sweep <= 1'b0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt      <= '0;
            acc      <= '0;
            fill_rgb <= in_rgb;
            res      <= '0;
            unique case (in_action)
              ACT_READ: state <= S_READ;
              ACT_FILL: state <= S_FILL;
              ACT_STEP: begin
                state <= S_STEP;
                sweep <= 1'b1;
              end
              default:  state <= S_REPLY;
            endcase
          end
        end
        S_READ: begin
          res.red   <= OUT_BITS'(cur_rdata[0 +: CHANNEL_BITS]);
          res.green <= OUT_BITS'(cur_rdata[CHANNEL_BITS +: CHANNEL_BITS]);
          res.blue  <= OUT_BITS'(cur_rdata[2*CHANNEL_BITS +: CHANNEL_BITS]);
          state     <= S_REPLY;
        end
        S_FILL: begin
          cnt <= AW'(cnt + 1'b1);
          if (cnt == LAST) begin
            state <= S_REPLY;
          end
        end
        S_STEP: begin
          if (sweep) begin
            cnt <= AW'(cnt + 1'b1);
            if (cnt == LAST) begin
              sweep <= 1'b0;
            end
          end
          pend      <= sweep;
          pend_addr <= cnt;
          if (pend) begin
            acc <= acc_total;
          end
          // last write-back: result is final
          if (pend && !sweep) begin
            res.matched_count <= count_sat;
            res.finished      <= (acc_total == ALL_HIT);
            state             <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `PFE_ASSERT_IMPL(a_one_write, clk, rst, 1'b1, !(ctl.cur_we && ctl.tgt_we))
  `PFE_ASSERT_IMPL(a_no_same_entry, clk, rst, ctl.rd_en && ctl.cur_we, rd_addr != wr_addr)
  `PFE_ASSERT_NEXT(a_step_ends, clk, rst, state == S_STEP && pend && !sweep, state == S_REPLY)
  `PFE_ASSERT_IMPL(a_reply_quiet, clk, rst, state == S_REPLY, ctl == '0)

endmodule

// File: rtl/palette_fade_engine_top.sv
// Palette fade engine: current and target palettes in two single-port-read memories.
// A write or unused action goes directly to the reply state, a read first loads the entry into
// the result, a fill writes every entry and a fade step sweeps every entry before the reply.
// One item at a time; a step sweeps through the palettes one entry per cycle on the memories'
// single read port.
// Reset clears control and fade_to_black; palette contents are not cleared.
module palette_fade_engine_top
  import pfe_pkg::*;
#(
  parameter int ENTRIES      = 256,
  parameter int CHANNEL_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,      // fade_to_black
  // item in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // action, entry_index, red_in, green_in, blue_in
  // result out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata        // red_out, green_out, blue_out, matched_count, finished
);

  localparam int AW = $clog2(ENTRIES);
  localparam int DW = 3 * CHANNEL_BITS;

  logic          fade_to_black;
  mem_ctl_t      ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [DW-1:0] cur_rdata;
  logic [DW-1:0] tgt_rdata;
  logic          res_valid;
  logic          res_take;
  result_t       res;
  result_t       out_res;

  // Mode register, written only while no item is in progress
  assign cfg_ready = s_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_to_black <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      fade_to_black <= cfg_data;
    end
  end

  pfe_ctrl #(
    .ENTRIES     (ENTRIES),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .fade_to_black(fade_to_black),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_action    (s_tdata[2:0]),
    .in_index     (s_tdata[10:3]),
    .in_red       (s_tdata[16:11]),
    .in_green     (s_tdata[22:17]),
    .in_blue      (s_tdata[28:23]),
    .ctl          (ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .cur_rdata    (cur_rdata),
    .tgt_rdata    (tgt_rdata),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  pfe_palette_mem #(
    .ENTRIES     (ENTRIES),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_mem (
    .clk      (clk),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .cur_rdata(cur_rdata),
    .tgt_rdata(tgt_rdata)
  );

  // Output register: loads when empty or draining
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res};

endmodule
